/* sv/ubp_pkg.sv */
// ----------------------------------------------------------------------------
// ubp_pkg
// shared types and constants for the buffered serial port engine
// ----------------------------------------------------------------------------
`default_nettype none

package ubp_pkg;

    localparam int unsigned MAX_SEQ_BYTES = 8;
    localparam logic [7:0]  ERROR_MARK    = 8'h7F;

    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_LINE_EVENT = 2'd2
    } op_t;

    typedef enum logic {
        REG_MATCH_PATTERN = 1'b0,
        REG_MATCH_LENGTH  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        FRONT_KEEP   = 2'd0,
        FRONT_MEM    = 2'd1,
        FRONT_BYPASS = 2'd2
    } front_src_t;

    typedef struct packed {
        logic [63:0] pattern;
        logic [3:0]  length;
    } match_cfg_t;

    typedef struct packed {
        logic       en;
        logic [7:0] rx_byte;
    } match_req_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] host_byte;
        logic       tx_ready;
        logic       rx_ready;
        logic [7:0] rx_byte;
        logic       error;
    } in_item_t;

    typedef struct packed {
        logic       read_valid;
        logic       send_valid;
        logic       send_direct;
        logic       write_accepted;
        logic       match_hit;
        logic [6:0] rx_count;
        logic [6:0] tx_room;
        logic       front_valid;
        front_src_t rx_src;
        logic [7:0] rx_byp;
        front_src_t tx_src;
        logic [7:0] host_byte;
    } stage_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       write_accepted;
        logic       match_hit;
        logic [6:0] rx_count;
        logic [6:0] tx_room;
        logic [7:0] front_byte;
        logic       front_valid;
    } result_t;

endpackage

`default_nettype wire

/* sv/ubp_ram.sv */
// ----------------------------------------------------------------------------
// ubp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ubp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ubp_seq_match.sv */
// ----------------------------------------------------------------------------
// ubp_seq_match
// wake sequence detector, one received byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module ubp_seq_match (
    input  logic              clk,
    input  logic              rst_n,
    input  ubp_pkg::match_cfg_t cfg,
    input  ubp_pkg::match_req_t req,
    output logic              hit
);

    import ubp_pkg::*;

    logic [2:0] matched_reg;
    logic [2:0] matched_next;
    logic [3:0] len_eff;
    logic [3:0] count_inc;
    logic [7:0] want;

    always_comb
    begin
        len_eff = cfg.length;
        if (len_eff == 4'd0)
        begin
            len_eff = 4'd1;
        end
        if (len_eff > 4'(MAX_SEQ_BYTES))
        begin
            len_eff = 4'(MAX_SEQ_BYTES);
        end
    end

    always_comb
    begin
        want         = cfg.pattern[{matched_reg, 3'b000} +: 8];
        count_inc    = {1'b0, matched_reg} + 4'd1;
        matched_next = matched_reg;
        hit          = 1'b0;
        if (req.en)
        begin
            if (req.rx_byte == want)
            begin
                if (count_inc >= len_eff)
                begin
                    hit          = 1'b1;
                    matched_next = 3'd0;
                end
                else
                begin
                    matched_next = count_inc[2:0];
                end
            end
            else
            begin
                matched_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matched_reg <= 3'd0;
        end
        else
        begin
            matched_reg <= matched_next;
        end
    end

endmodule

`default_nettype wire

/* sv/uart_buffered_port_with_sequence_match.sv */
// ----------------------------------------------------------------------------
// uart_buffered_port_with_sequence_match
// serial port buffering engine: receive ring, transmit ring, wake sequence
// ----------------------------------------------------------------------------
//  channel   | handshake              | beat contents
//  ----------+------------------------+---------------------------------------
//  input     | in_valid / in_ready    | op, host byte, line status fields
//  result    | out_valid / out_ready  | read, send, status and peek fields
//  config    | apb write, pready = 1  | match_pattern @0x0, match_length @0x8
//
//  one beat per cycle while no stall holds it; a line event that stores both a
//  received byte and the error mark holds back the next beat while the mark
//  takes the receive ram write port; each beat is registered in s1, s2 and s3
//  reset empties both rings at once, ring contents need no clearing pass
//  a stalled result beat holds the pipeline and drops in_ready
// ----------------------------------------------------------------------------
`default_nettype none

module uart_buffered_port_with_sequence_match #(
    parameter int unsigned RING_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  host_byte,
    input  logic        line_tx_ready,
    input  logic        line_rx_ready,
    input  logic [7:0]  line_rx_byte,
    input  logic        line_error,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        send_valid,
    output logic [7:0]  send_byte,
    output logic        write_accepted,
    output logic        match_hit,
    output logic [6:0]  rx_count,
    output logic [6:0]  tx_room,
    output logic [7:0]  front_byte,
    output logic        front_valid
);

    import ubp_pkg::*;

    localparam int unsigned     PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [63:0] pattern_reg;
    logic [3:0]  length_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_sel;
    match_cfg_t  match_cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = reg_idx_t'(paddr[3]);
    assign prdata  = (cfg_sel == REG_MATCH_LENGTH) ? {60'd0, length_reg} : pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= 64'd0;
            length_reg  <= 4'd1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_MATCH_PATTERN: pattern_reg <= pwdata;
                REG_MATCH_LENGTH:  length_reg  <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    assign match_cfg.pattern = pattern_reg;
    assign match_cfg.length  = length_reg;

    // pipeline control
    logic     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    in_item_t s1_reg;
    stage_t   s2_reg;
    result_t  s3_reg;
    logic     in_fire, s1_go, s2_ready, s2_adv, s3_ready;

    logic     pend_valid_reg, pend_valid_next;
    logic [PTR_W-1:0] pend_addr_reg, pend_addr_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_go    = s1_valid_reg && s2_ready && !pend_valid_reg;
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;

    // ring pointers and fill counts
    logic [PTR_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PTR_W-1:0] rx_used_reg, rx_used_next;
    logic [PTR_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0] tx_used_reg, tx_used_next;
    logic [PTR_W-1:0] rx_head_a, rx_used_a;
    logic             push_byte, push_mark;

    logic             rx_s1_wr_en;
    logic [PTR_W-1:0] rx_s1_wr_addr;
    logic [7:0]       rx_s1_wr_data;
    logic             rx_wr_en;
    logic [PTR_W-1:0] rx_wr_addr;
    logic [7:0]       rx_wr_data;
    logic [7:0]       rx_rd_data;
    logic             tx_wr_en;
    logic [7:0]       tx_rd_data;

    match_req_t match_req;
    logic       hit;
    stage_t     s1_res;

    ubp_seq_match u_seq_match (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (match_cfg),
        .req   (match_req),
        .hit   (hit)
    );

    always_comb
    begin
        rx_head_next   = rx_head_reg;
        rx_tail_next   = rx_tail_reg;
        rx_used_next   = rx_used_reg;
        tx_head_next   = tx_head_reg;
        tx_tail_next   = tx_tail_reg;
        tx_used_next   = tx_used_reg;
        pend_valid_next = 1'b0;
        pend_addr_next = pend_addr_reg;
        rx_head_a      = rx_head_reg;
        rx_used_a      = rx_used_reg;
        push_byte      = 1'b0;
        push_mark      = 1'b0;
        rx_s1_wr_en    = 1'b0;
        rx_s1_wr_addr  = rx_head_reg;
        rx_s1_wr_data  = s1_reg.rx_byte;
        tx_wr_en       = 1'b0;
        match_req.en      = 1'b0;
        match_req.rx_byte = s1_reg.rx_byte;

        s1_res                = '0;
        s1_res.rx_src         = FRONT_KEEP;
        s1_res.tx_src         = FRONT_KEEP;
        s1_res.rx_byp         = s1_reg.rx_byte;
        s1_res.host_byte      = s1_reg.host_byte;

        if (s1_go)
        begin
            unique case (s1_reg.op)
                OP_HOST_WRITE:
                begin
                    if (s1_reg.tx_ready && tx_used_reg == '0)
                    begin
                        s1_res.send_valid     = 1'b1;
                        s1_res.send_direct    = 1'b1;
                        s1_res.write_accepted = 1'b1;
                    end
                    else if (tx_used_reg != LAST_IDX)
                    begin
                        tx_wr_en              = 1'b1;
                        tx_head_next          = ring_next(tx_head_reg);
                        tx_used_next          = tx_used_reg + 1'b1;
                        s1_res.write_accepted = 1'b1;
                        if (tx_used_reg == '0)
                        begin
                            s1_res.tx_src = FRONT_BYPASS;
                        end
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_used_reg != '0)
                    begin
                        s1_res.read_valid = 1'b1;
                        rx_tail_next      = ring_next(rx_tail_reg);
                        rx_used_next      = rx_used_reg - 1'b1;
                        s1_res.rx_src     = FRONT_MEM;
                    end
                end
                OP_LINE_EVENT:
                begin
                    match_req.en = s1_reg.rx_ready;
                    push_byte    = s1_reg.rx_ready && (rx_used_reg != LAST_IDX);
                    rx_used_a    = push_byte ? rx_used_reg + 1'b1 : rx_used_reg;
                    rx_head_a    = push_byte ? ring_next(rx_head_reg) : rx_head_reg;
                    push_mark    = s1_reg.error && (rx_used_a != LAST_IDX);
                    if (push_byte)
                    begin
                        rx_s1_wr_en = 1'b1;
                    end
                    if (push_mark)
                    begin
                        if (push_byte)
                        begin
                            // mark goes to the ram on the next cycle
                            pend_valid_next = 1'b1;
                            pend_addr_next  = rx_head_a;
                        end
                        else
                        begin
                            rx_s1_wr_en   = 1'b1;
                            rx_s1_wr_data = ERROR_MARK;
                        end
                    end
                    rx_head_next = push_mark ? ring_next(rx_head_a) : rx_head_a;
                    rx_used_next = push_mark ? rx_used_a + 1'b1 : rx_used_a;
                    if (rx_used_reg == '0 && (push_byte || push_mark))
                    begin
                        s1_res.rx_src = FRONT_BYPASS;
                        s1_res.rx_byp = push_byte ? s1_reg.rx_byte : ERROR_MARK;
                    end
                    if (s1_reg.tx_ready && tx_used_reg != '0)
                    begin
                        s1_res.send_valid = 1'b1;
                        tx_tail_next      = ring_next(tx_tail_reg);
                        tx_used_next      = tx_used_reg - 1'b1;
                        s1_res.tx_src     = FRONT_MEM;
                    end
                end
                default: ;
            endcase
        end

        s1_res.match_hit   = hit;
        s1_res.rx_count    = 7'(rx_used_next);
        s1_res.tx_room     = 7'(LAST_IDX - tx_used_next);
        s1_res.front_valid = (rx_used_next != '0);
    end

    assign rx_wr_en   = pend_valid_reg || rx_s1_wr_en;
    assign rx_wr_addr = pend_valid_reg ? pend_addr_reg : rx_s1_wr_addr;
    assign rx_wr_data = pend_valid_reg ? ERROR_MARK : rx_s1_wr_data;

    ubp_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (s1_go),
        .rd_addr (rx_tail_next),
        .rd_data (rx_rd_data)
    );

    ubp_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_head_reg),
        .wr_data (s1_reg.host_byte),
        .rd_en   (s1_go),
        .rd_addr (tx_tail_next),
        .rd_data (tx_rd_data)
    );

    // front of each ring, kept in item order
    logic [7:0] rx_front_reg, rx_front_next;
    logic [7:0] tx_front_reg, tx_front_next;
    result_t    s2_res;

    always_comb
    begin
        unique case (s2_reg.rx_src)
            FRONT_MEM:    rx_front_next = rx_rd_data;
            FRONT_BYPASS: rx_front_next = s2_reg.rx_byp;
            default:      rx_front_next = rx_front_reg;
        endcase
        unique case (s2_reg.tx_src)
            FRONT_MEM:    tx_front_next = tx_rd_data;
            FRONT_BYPASS: tx_front_next = s2_reg.host_byte;
            default:      tx_front_next = tx_front_reg;
        endcase

        s2_res.read_valid     = s2_reg.read_valid;
        s2_res.read_byte      = s2_reg.read_valid ? rx_front_reg : 8'd0;
        s2_res.send_valid     = s2_reg.send_valid;
        if (!s2_reg.send_valid)
        begin
            s2_res.send_byte = 8'd0;
        end
        else if (s2_reg.send_direct)
        begin
            s2_res.send_byte = s2_reg.host_byte;
        end
        else
        begin
            s2_res.send_byte = tx_front_reg;
        end
        s2_res.write_accepted = s2_reg.write_accepted;
        s2_res.match_hit      = s2_reg.match_hit;
        s2_res.rx_count       = s2_reg.rx_count;
        s2_res.tx_room        = s2_reg.tx_room;
        s2_res.front_valid    = s2_reg.front_valid;
        s2_res.front_byte     = s2_reg.front_valid ? rx_front_next : 8'd0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            rx_used_reg    <= '0;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            tx_used_reg    <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s3_valid_reg <= 1'b0;
            end
            pend_valid_reg <= pend_valid_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            rx_used_reg    <= rx_used_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            tx_used_reg    <= tx_used_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        if (in_fire)
        begin
            s1_reg.op        <= op;
            s1_reg.host_byte <= host_byte;
            s1_reg.tx_ready  <= line_tx_ready;
            s1_reg.rx_ready  <= line_rx_ready;
            s1_reg.rx_byte   <= line_rx_byte;
            s1_reg.error     <= line_error;
        end
        if (s1_go)
        begin
            s2_reg <= s1_res;
        end
        if (s2_adv)
        begin
            s3_reg       <= s2_res;
            rx_front_reg <= rx_front_next;
            tx_front_reg <= tx_front_next;
        end
    end

    assign out_valid      = s3_valid_reg;
    assign read_byte      = s3_reg.read_byte;
    assign read_valid     = s3_reg.read_valid;
    assign send_valid     = s3_reg.send_valid;
    assign send_byte      = s3_reg.send_byte;
    assign write_accepted = s3_reg.write_accepted;
    assign match_hit      = s3_reg.match_hit;
    assign rx_count       = s3_reg.rx_count;
    assign tx_room        = s3_reg.tx_room;
    assign front_byte     = s3_reg.front_byte;
    assign front_valid    = s3_reg.front_valid;

endmodule

`default_nettype wire

/* sim/uart_buffered_port_with_sequence_match_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_buffered_port_with_sequence_match_tb
// self-checking bench for the buffered serial port engine: host writes and
// reads, line events, both rings running full and the wake sequence detector
// are driven through the valid/ready input channel, and every result beat is
// checked against an in-bench model of the rings and the detector
// ----------------------------------------------------------------------------
module uart_buffered_port_with_sequence_match_tb;

    import ubp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        PH_WAKE,
        PH_FILL_TX,
        PH_FILL_RX,
        PH_MIXED
    } phase_kind_t;

    class serial_port_scoreboard;
        bit [7:0]    rx_mem [128];
        bit [7:0]    tx_mem [128];
        bit [6:0]    rx_wr, rx_rd, tx_wr, tx_rd;
        int unsigned seq_pos;
        bit [63:0]   wake_pattern;
        bit [3:0]    wake_len;
        result_t     pending_results [$];
        int          errors;

        function new();
            rx_wr        = '0;
            rx_rd        = '0;
            tx_wr        = '0;
            tx_rd        = '0;
            seq_pos      = 0;
            wake_pattern = '0;
            wake_len     = 4'd1;
            errors       = 0;
        endfunction

        function int unsigned span();
            if (wake_len < 1)
                return 1;
            if (wake_len > MAX_SEQ_BYTES)
                return MAX_SEQ_BYTES;
            return wake_len;
        endfunction

        function void set_register(reg_idx_t idx, bit [63:0] value);
            if (idx == REG_MATCH_PATTERN)
                wake_pattern = value;
            else
                wake_len = value[3:0];
        endfunction

        function void store_rx(bit [7:0] b);
            if (rx_wr + 7'd1 != rx_rd)
            begin
                rx_mem[rx_wr] = b;
                rx_wr++;
            end
        endfunction

        function bit step_wake(bit [7:0] b);
            int unsigned idx;
            idx = seq_pos & 7;
            if (b == wake_pattern[8*idx +: 8])
            begin
                seq_pos = idx + 1;
                if (seq_pos >= span())
                begin
                    seq_pos = 0;
                    return 1'b1;
                end
                return 1'b0;
            end
            seq_pos = 0;
            return 1'b0;
        endfunction

        function void note_input(in_item_t beat);
            result_t r;
            r = '0;
            case (beat.op)
                OP_HOST_WRITE:
                begin
                    if (beat.tx_ready && tx_wr == tx_rd)
                    begin
                        r.send_valid     = 1'b1;
                        r.send_byte      = beat.host_byte;
                        r.write_accepted = 1'b1;
                    end
                    else if (tx_wr + 7'd1 != tx_rd)
                    begin
                        tx_mem[tx_wr] = beat.host_byte;
                        tx_wr++;
                        r.write_accepted = 1'b1;
                    end
                end
                OP_HOST_READ:
                begin
                    if (rx_wr != rx_rd)
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte  = rx_mem[rx_rd];
                        rx_rd++;
                    end
                end
                OP_LINE_EVENT:
                begin
                    if (beat.rx_ready)
                    begin
                        r.match_hit = step_wake(beat.rx_byte);
                        store_rx(beat.rx_byte);
                    end
                    if (beat.tx_ready && tx_wr != tx_rd)
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte  = tx_mem[tx_rd];
                        tx_rd++;
                    end
                    if (beat.error)
                        store_rx(ERROR_MARK);
                end
                default:
                begin
                end
            endcase
            r.rx_count    = rx_wr - rx_rd;
            r.tx_room     = 7'd127 - 7'(tx_wr - tx_rd);
            r.front_valid = rx_wr != rx_rd;
            if (r.front_valid)
                r.front_byte = rx_mem[rx_rd];
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, int unsigned exp, int unsigned got);
            if (exp != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            check_field("read_byte", exp.read_byte, got.read_byte);
            check_field("read_valid", exp.read_valid, got.read_valid);
            check_field("send_valid", exp.send_valid, got.send_valid);
            check_field("send_byte", exp.send_byte, got.send_byte);
            check_field("write_accepted", exp.write_accepted, got.write_accepted);
            check_field("match_hit", exp.match_hit, got.match_hit);
            check_field("rx_count", exp.rx_count, got.rx_count);
            check_field("tx_room", exp.tx_room, got.tx_room);
            check_field("front_byte", exp.front_byte, got.front_byte);
            check_field("front_valid", exp.front_valid, got.front_valid);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  host_byte;
    logic        line_tx_ready;
    logic        line_rx_ready;
    logic [7:0]  line_rx_byte;
    logic        line_error;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        write_accepted;
    logic        match_hit;
    logic [6:0]  rx_count;
    logic [6:0]  tx_room;
    logic [7:0]  front_byte;
    logic        front_valid;

    serial_port_scoreboard sb = new();
    bit          steady = 1'b0;
    int unsigned feed_pos = 0;

    uart_buffered_port_with_sequence_match uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .host_byte      (host_byte),
        .line_tx_ready  (line_tx_ready),
        .line_rx_ready  (line_rx_ready),
        .line_rx_byte   (line_rx_byte),
        .line_error     (line_error),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_byte      (read_byte),
        .read_valid     (read_valid),
        .send_valid     (send_valid),
        .send_byte      (send_byte),
        .write_accepted (write_accepted),
        .match_hit      (match_hit),
        .rx_count       (rx_count),
        .tx_room        (tx_room),
        .front_byte     (front_byte),
        .front_valid    (front_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    function automatic in_item_t make_beat(logic [1:0] o, logic [7:0] hb, logic txr,
                                           logic rxr, logic [7:0] rxb, logic err);
        in_item_t beat;
        beat.op        = o;
        beat.host_byte = hb;
        beat.tx_ready  = txr;
        beat.rx_ready  = rxr;
        beat.rx_byte   = rxb;
        beat.error     = err;
        return beat;
    endfunction

    function automatic in_item_t draw_beat(phase_kind_t kind);
        in_item_t    beat;
        int unsigned r;
        beat = make_beat(2'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom), 8'($urandom), 1'($urandom));
        r    = $urandom_range(0, 99);
        case (kind)
            PH_WAKE:
            begin
                if (r < 20)
                    beat.op = OP_HOST_READ;
                else if (r < 25)
                    beat.op = OP_HOST_WRITE;
                else if (r < 27)
                    beat.op = OP_UNUSED;
                else
                begin
                    beat.op       = OP_LINE_EVENT;
                    beat.rx_ready = $urandom_range(0, 9) != 0;
                    beat.error    = $urandom_range(0, 9) == 0;
                    if (beat.rx_ready)
                    begin
                        if ($urandom_range(0, 99) < 85)
                        begin
                            beat.rx_byte = sb.wake_pattern[8*feed_pos +: 8];
                            feed_pos     = (feed_pos + 1) % sb.span();
                        end
                        else
                            feed_pos = 0;
                    end
                end
            end
            PH_FILL_TX:
            begin
                if (r < 85)
                begin
                    beat.op       = OP_HOST_WRITE;
                    beat.tx_ready = $urandom_range(0, 19) == 0;
                end
                else if (r < 90)
                begin
                    beat.op       = OP_LINE_EVENT;
                    beat.tx_ready = 1'b0;
                end
                else
                    beat.op = OP_HOST_READ;
            end
            PH_FILL_RX:
            begin
                if (r < 80)
                begin
                    beat.op       = OP_LINE_EVENT;
                    beat.rx_ready = 1'b1;
                    beat.error    = $urandom_range(0, 9) < 3;
                end
                else if (r < 90)
                    beat.op = OP_HOST_READ;
                else
                    beat.op = OP_HOST_WRITE;
            end
            default:
            begin
                if (r < 30)
                    beat.op = OP_HOST_WRITE;
                else if (r < 60)
                    beat.op = OP_HOST_READ;
                else if (r < 97)
                    beat.op = OP_LINE_EVENT;
                else
                    beat.op = OP_UNUSED;
            end
        endcase
        return beat;
    endfunction

    task automatic send_item(in_item_t beat);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= beat.op;
        host_byte     <= beat.host_byte;
        line_tx_ready <= beat.tx_ready;
        line_rx_ready <= beat.rx_ready;
        line_rx_byte  <= beat.rx_byte;
        line_error    <= beat.error;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(beat);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [63:0] value);
        wait_for_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic run_phase(phase_kind_t kind, int count, logic [63:0] pattern,
                             logic [3:0] len, int steady_lead);
        write_register(REG_MATCH_PATTERN, pattern);
        write_register(REG_MATCH_LENGTH, {60'd0, len});
        feed_pos = 0;
        for (int i = 0; i < count; i++)
        begin
            steady = i < steady_lead;
            if (i == count / 2)
                wait_for_drain();
            send_item(draw_beat(kind));
        end
        steady = 1'b0;
    endtask

    // result side: random stalls per beat
    initial
    begin
        result_t got;
        int      hold;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.read_byte      = read_byte;
            got.read_valid     = read_valid;
            got.send_valid     = send_valid;
            got.send_byte      = send_byte;
            got.write_accepted = write_accepted;
            got.match_hit      = match_hit;
            got.rx_count       = rx_count;
            got.tx_room        = tx_room;
            got.front_byte     = front_byte;
            got.front_valid    = front_valid;
            sb.check_result(got);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        op            <= OP_HOST_WRITE;
        host_byte     <= '0;
        line_tx_ready <= 1'b0;
        line_rx_ready <= 1'b0;
        line_rx_byte  <= '0;
        line_error    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: wake on a single zero byte
        send_item(make_beat(OP_HOST_READ, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1));
        send_item(make_beat(OP_UNUSED, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1));
        send_item(make_beat(OP_LINE_EVENT, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1));
        send_item(make_beat(OP_HOST_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0));
        send_item(make_beat(OP_HOST_WRITE, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b1));
        send_item(make_beat(OP_HOST_WRITE, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1));
        repeat (5)
            send_item(make_beat(OP_HOST_READ, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0));

        // count left past a shortened length completes on the next match
        write_register(REG_MATCH_PATTERN, 64'h8877_6655_4433_2211);
        write_register(REG_MATCH_LENGTH, 64'd8);
        for (int i = 0; i < 5; i++)
            send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'(8'h11 * (i + 1)), 1'b0));
        write_register(REG_MATCH_LENGTH, 64'd2);
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h66, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h11, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h22, 1'b0));
        // mismatch does not restart on the same byte
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h11, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h11, 1'b0));
        send_item(make_beat(OP_LINE_EVENT, 8'h00, 1'b0, 1'b1, 8'h22, 1'b0));

        run_phase(PH_WAKE, 130, {$urandom, $urandom}, 4'd8, 40);
        run_phase(PH_FILL_TX, 170, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 0);
        run_phase(PH_MIXED, 100, 64'h0, 4'd0, 40);
        run_phase(PH_FILL_RX, 170, {$urandom, $urandom}, 4'd3, 0);
        run_phase(PH_WAKE, 100, 64'h4141_4141_4141_4141, 4'd9, 40);
        run_phase(PH_MIXED, 80, {$urandom, $urandom}, 4'd1, 0);

        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
sv/ubp_pkg.sv
sv/ubp_ram.sv
sv/ubp_seq_match.sv
sv/uart_buffered_port_with_sequence_match.sv
sim/uart_buffered_port_with_sequence_match_tb.sv
